### rtl/core/mi3_pkg.sv
// Shared types and constants for the 3x3 matrix inverse pipeline.
// Used by every module under rtl/core; has no dependencies.
package mi3_pkg;

   localparam int ELEM_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   localparam int PROD_W  = 2 * ELEM_WIDTH;
   localparam int ADJ_W   = 2 * ELEM_WIDTH + 1;
   localparam int SPLIT_W = ADJ_W - ELEM_WIDTH;
   localparam int LO_W    = ELEM_WIDTH + SPLIT_W + 1;
   localparam int DET_W   = 3 * ELEM_WIDTH + 3;
   localparam int NUM_W   = ADJ_W + 2 * FRAC_BITS;
   localparam int QUO_W   = ELEM_WIDTH + 1;
   localparam int CMP_W   = DET_W + QUO_W;
   // Sign/magnitude stage, overflow check stage, then one stage per quotient bit.
   localparam int DIV_LAT = QUO_W + 2;

   // Operand indexes of each cofactor: adj = m[a]*m[b] - m[c]*m[d].
   localparam int COF_IDX [9][4] = '{
      '{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 2, 4},
      '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
      '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
   };

   typedef logic signed [ELEM_WIDTH-1:0] elem_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [ADJ_W-1:0]      adj_type;
   typedef logic signed [LO_W-1:0]       lo_type;
   typedef logic signed [DET_W-1:0]      det_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SINGULAR  = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

   typedef struct packed {
      elem_type a00; elem_type a01; elem_type a02;
      elem_type a10; elem_type a11; elem_type a12;
      elem_type a20; elem_type a21; elem_type a22;
   } matrix_type;

   typedef struct packed {
      elem_type r00; elem_type r01; elem_type r02;
      elem_type r10; elem_type r11; elem_type r12;
      elem_type r20; elem_type r21; elem_type r22;
      status_type status;
   } result_type;

endpackage

### rtl/core/mi3_adjugate.sv
// Three-stage front end: input register, 18 element products, nine cofactors.
// Depends on mi3_pkg.
module mi3_adjugate import mi3_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic       in_valid,
   input  matrix_type in_mat,
   output logic       out_valid,
   output adj_type    adj_o [9],
   output elem_type   row0_o [3]
);

   elem_type m_in [9];
   elem_type m_ff [9];
   prod_type prod_in [18];
   prod_type prod_ff [18];
   adj_type  adj_in [9];
   adj_type  adj_ff [9];
   elem_type row_s2_ff [3];
   elem_type row_s3_ff [3];
   logic [2:0] valid_ff;

   always_comb begin
      m_in = '{in_mat.a00, in_mat.a01, in_mat.a02,
               in_mat.a10, in_mat.a11, in_mat.a12,
               in_mat.a20, in_mat.a21, in_mat.a22};
   end

   for (genvar k = 0; k < 9; k++) begin : g_cof
      assign prod_in[2*k]   = m_ff[COF_IDX[k][0]] * m_ff[COF_IDX[k][1]];
      assign prod_in[2*k+1] = m_ff[COF_IDX[k][2]] * m_ff[COF_IDX[k][3]];
      assign adj_in[k]      = ADJ_W'(prod_ff[2*k]) - ADJ_W'(prod_ff[2*k+1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff      <= m_in;
         prod_ff   <= prod_in;
         adj_ff    <= adj_in;
         row_s2_ff <= m_ff[0:2];
         row_s3_ff <= row_s2_ff;
      end
   end

   assign out_valid = valid_ff[2];
   assign adj_o     = adj_ff;
   assign row0_o    = row_s3_ff;

endmodule

### rtl/core/mi3_determinant.sv
// Three-stage determinant: split products along row 0, term assembly, final sum.
// Depends on mi3_pkg; the cofactors travel alongside unchanged.
module mi3_determinant import mi3_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  adj_type  adj_i [9],
   input  elem_type row0_i [3],
   output logic     out_valid,
   output adj_type  adj_o [9],
   output det_type  det_o
);

   prod_type hi_in [3];
   prod_type hi_ff [3];
   lo_type   lo_in [3];
   lo_type   lo_ff [3];
   det_type  term_in [3];
   det_type  term_ff [3];
   det_type  det_in;
   det_type  det_ff;
   adj_type  adj_s4_ff [9];
   adj_type  adj_s5_ff [9];
   adj_type  adj_s6_ff [9];
   logic [2:0] valid_ff;

   // Each 32 x 65 product is split by cutting the cofactor into a signed high half and an unsigned low half.
   for (genvar t = 0; t < 3; t++) begin : g_term
      logic signed [ELEM_WIDTH-1:0] hi_part;
      logic signed [SPLIT_W:0]      lo_part;
      assign hi_part    = adj_i[3*t][ADJ_W-1:SPLIT_W];
      assign lo_part    = {1'b0, adj_i[3*t][SPLIT_W-1:0]};
      assign hi_in[t]   = row0_i[t] * hi_part;
      assign lo_in[t]   = row0_i[t] * lo_part;
      assign term_in[t] = (DET_W'(hi_ff[t]) <<< SPLIT_W) + DET_W'(lo_ff[t]);
   end

   assign det_in = term_ff[0] + term_ff[1] + term_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hi_ff     <= hi_in;
         lo_ff     <= lo_in;
         term_ff   <= term_in;
         det_ff    <= det_in;
         adj_s4_ff <= adj_i;
         adj_s5_ff <= adj_s4_ff;
         adj_s6_ff <= adj_s5_ff;
      end
   end

   assign out_valid = valid_ff[2];
   assign adj_o     = adj_s6_ff;
   assign det_o     = det_ff;

endmodule

### rtl/core/mi3_divider.sv
// Pipelined restoring divider for one element: adj * 2^(2F) / det, truncated
// toward zero and saturated, one quotient bit per stage. Depends on mi3_pkg.
module mi3_divider import mi3_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  adj_type  adj_i,
   input  det_type  det_i,
   output elem_type res_o,
   output logic     sat_o
);

   adj_type           adj_abs;
   det_type           det_abs;
   logic [NUM_W-1:0]  num_ff;
   logic [DET_W-1:0]  den_ff;
   logic              neg_ff;
   logic [NUM_W-1:0]  b_rem_ff;
   logic [DET_W-1:0]  b_den_ff;
   logic              b_neg_ff;
   logic              b_big_ff;

   logic [NUM_W-1:0]  rem_ff [QUO_W];
   logic [QUO_W-1:0]  quo_ff [QUO_W];
   logic [DET_W-1:0]  den_s_ff [QUO_W];
   logic              neg_s_ff [QUO_W];
   logic              big_s_ff [QUO_W];

   logic [QUO_W-1:0]      q;
   logic [ELEM_WIDTH-1:0] q_low;
   logic                  sat_pos;
   logic                  sat_neg;

   assign adj_abs = adj_i[ADJ_W-1] ? -adj_i : adj_i;
   assign det_abs = det_i[DET_W-1] ? -det_i : det_i;

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff   <= NUM_W'($unsigned(adj_abs)) << (2 * FRAC_BITS);
         den_ff   <= $unsigned(det_abs);
         neg_ff   <= adj_i[ADJ_W-1] ^ det_i[DET_W-1];
         // Quotient would need more than QUO_W bits.
         b_big_ff <= CMP_W'(num_ff >> QUO_W) >= CMP_W'(den_ff);
         b_rem_ff <= num_ff;
         b_den_ff <= den_ff;
         b_neg_ff <= neg_ff;
      end
   end

   for (genvar j = 0; j < QUO_W; j++) begin : g_bit
      logic [NUM_W-1:0] rem_src;
      logic [QUO_W-1:0] quo_src;
      logic [DET_W-1:0] den_src;
      logic             neg_src;
      logic             big_src;
      logic [CMP_W:0]   trial;
      logic             ge;

      if (j == 0) begin : g_first
         assign rem_src = b_rem_ff;
         assign quo_src = '0;
         assign den_src = b_den_ff;
         assign neg_src = b_neg_ff;
         assign big_src = b_big_ff;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign quo_src = quo_ff[j-1];
         assign den_src = den_s_ff[j-1];
         assign neg_src = neg_s_ff[j-1];
         assign big_src = big_s_ff[j-1];
      end

      assign trial = {1'b0, CMP_W'(rem_src)} -
                     {1'b0, CMP_W'(den_src) << (QUO_W - 1 - j)};
      assign ge    = ~trial[CMP_W];

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]   <= ge ? trial[NUM_W-1:0] : rem_src;
            quo_ff[j]   <= {quo_src[QUO_W-2:0], ge};
            den_s_ff[j] <= den_src;
            neg_s_ff[j] <= neg_src;
            big_s_ff[j] <= big_src;
         end
      end
   end

   assign q       = quo_ff[QUO_W-1];
   assign q_low   = q[ELEM_WIDTH-1:0];
   assign sat_pos = big_s_ff[QUO_W-1] | q[QUO_W-1] | q[QUO_W-2];
   assign sat_neg = big_s_ff[QUO_W-1] | q[QUO_W-1] |
                    (q[QUO_W-2] & (|q[QUO_W-3:0]));

   always_comb begin
      if (neg_s_ff[QUO_W-1]) begin
         sat_o = sat_neg;
         res_o = sat_neg ? {1'b1, {(ELEM_WIDTH-1){1'b0}}} : -q_low;
      end else begin
         sat_o = sat_pos;
         res_o = sat_pos ? {1'b0, {(ELEM_WIDTH-1){1'b1}}} : q_low;
      end
   end

endmodule

### rtl/core/matrix3x3_inverse.sv
// 3x3 matrix inverse by the adjugate method, signed Q16.16 in and out.
// Depends on mi3_pkg, mi3_adjugate, mi3_determinant and mi3_divider.
//
// Request channel (req_valid, req_stall, req_data) takes one matrix per transfer
// in row-major order. Response channel (rsp_valid, rsp_stall, rsp_data) returns
// the inverse and a status: ok, singular (all elements zero) or saturated.
// Each element is adj * 2^32 / det, truncated toward zero and clipped to 32 bits.
//
// Throughput: one matrix per cycle while the pipeline is not stalled. From request
// transfer to rsp_valid a matrix passes 3 cofactor stages, 3 determinant stages,
// 35 divider stages (sign, overflow check, one per quotient bit) and the output register.
// The divider chain of 33 quotient-bit stages sets the latency.
//
// Stall: the whole pipeline holds while a result sits in the output register and
// rsp_stall is high; req_stall is raised in those cycles only, so nothing is lost
// or repeated. Reset (synchronous) clears all valid bits; payload is not cleared.
module matrix3x3_inverse import mi3_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  matrix_type req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_data
);

   logic     en;
   logic     adj_valid;
   adj_type  adj_a [9];
   elem_type row0 [3];
   logic     det_valid;
   adj_type  adj_d [9];
   det_type  det;
   elem_type res [9];
   logic     sat [9];
   logic [DIV_LAT-1:0] valid_ff;
   logic [DIV_LAT-1:0] zero_ff;
   logic       rsp_valid_ff;
   result_type rsp_data_ff;
   result_type rsp_data_in;

   assign en        = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = ~en;

   mi3_adjugate u_adj (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_mat    (req_data),
      .out_valid (adj_valid),
      .adj_o     (adj_a),
      .row0_o    (row0)
   );

   mi3_determinant u_det (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (adj_valid),
      .adj_i     (adj_a),
      .row0_i    (row0),
      .out_valid (det_valid),
      .adj_o     (adj_d),
      .det_o     (det)
   );

   for (genvar k = 0; k < 9; k++) begin : g_div
      mi3_divider u_div (
         .clock (clock),
         .en    (en),
         .adj_i (adj_d[k]),
         .det_i (det),
         .res_o (res[k]),
         .sat_o (sat[k])
      );
   end

   // Valid and singular flags run beside the divider stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff     <= {valid_ff[DIV_LAT-2:0], det_valid};
         rsp_valid_ff <= valid_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff     <= {zero_ff[DIV_LAT-2:0], det == '0};
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_comb begin
      if (zero_ff[DIV_LAT-1]) begin
         rsp_data_in        = '0;
         rsp_data_in.status = STATUS_SINGULAR;
      end else begin
         rsp_data_in = '{r00: res[0], r01: res[1], r02: res[2],
                         r10: res[3], r11: res[4], r12: res[5],
                         r20: res[6], r21: res[7], r22: res[8],
                         status: STATUS_OK};
         if (sat[0] | sat[1] | sat[2] | sat[3] | sat[4] |
             sat[5] | sat[6] | sat[7] | sat[8]) begin
            rsp_data_in.status = STATUS_SATURATED;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/core/mi3_checker.sv
// Port-level checks for matrix3x3_inverse, attached by the bind below.
// Depends on mi3_pkg.
module mi3_checker import mi3_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input result_type rsp_data
);

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Input is held back only while a finished result waits.
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall does not follow the output register");

   // A singular result carries all-zero elements.
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_SINGULAR) |->
      (rsp_data.r00 == '0 && rsp_data.r01 == '0 && rsp_data.r02 == '0 &&
       rsp_data.r10 == '0 && rsp_data.r11 == '0 && rsp_data.r12 == '0 &&
       rsp_data.r20 == '0 && rsp_data.r21 == '0 && rsp_data.r22 == '0))
      else $error("singular result with nonzero elements");

   // A stalled response is neither dropped nor altered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind matrix3x3_inverse mi3_checker u_mi3_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
